@@ rtl/nearest_centroid_assign_top_assert.svh @@
// assertion macros for the nearest centroid block
`ifndef NEAREST_CENTROID_ASSIGN_TOP_ASSERT_SVH
`define NEAREST_CENTROID_ASSIGN_TOP_ASSERT_SVH

`ifndef SYNTH
`define NCA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nearest centroid assertion failed");
`define NCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nearest centroid assertion failed");
`else
`define NCA_ASSERT_NOW(lbl, ante, cons)
`define NCA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ rtl/nca_pkg.sv @@
`default_nettype none

package nca_pkg;

  localparam int LABEL_W    = 4;
  localparam int DIST_W     = 38;
  localparam int SUM_W      = 64;
  localparam int CNT_W      = 9;
  localparam int FIELD_W    = 4;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  typedef logic [LABEL_W-1:0]    label_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [FIELD_W-1:0]    field_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLUSTERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS     = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  typedef struct packed {
    logic valid;
    logic first_dim;
    logic last_dim;
    logic first_cluster;
    logic last_cluster;
  } step_tag_t;

  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/nca_store.sv @@
`default_nettype none

module nca_store #(
  parameter int CIW        = 4,
  parameter int DIW        = 4,
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  cen_we_i,
  input  wire logic [CIW+DIW-1:0]    cen_waddr_i,
  input  wire logic                  pt_we_i,
  input  wire logic [DIW-1:0]        pt_waddr_i,
  input  wire logic [COORD_BITS-1:0] wdata_i,
  input  wire logic [CIW+DIW-1:0]    cen_raddr_i,
  input  wire logic [DIW-1:0]        pt_raddr_i,
  output logic      [COORD_BITS-1:0] cen_rdata_o,
  output logic      [COORD_BITS-1:0] pt_rdata_o
);

  localparam int CDEPTH = 2 ** (CIW + DIW);
  localparam int PDEPTH = 2 ** DIW;

  logic [COORD_BITS-1:0] cen_mem [CDEPTH];
  logic [COORD_BITS-1:0] pt_mem  [PDEPTH];

  always_ff @(posedge clk_i) begin
    if (cen_we_i) begin
      cen_mem[cen_waddr_i] <= wdata_i;
    end
    cen_rdata_o <= cen_mem[cen_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (pt_we_i) begin
      pt_mem[pt_waddr_i] <= wdata_i;
    end
    pt_rdata_o <= pt_mem[pt_raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/nca_dist_unit.sv @@
`default_nettype none

module nca_dist_unit #(
  parameter int CIW        = 4,
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire nca_pkg::step_tag_t    tag_i,
  input  wire logic [CIW-1:0]        cluster_i,
  input  wire logic [COORD_BITS-1:0] cen_i,
  input  wire logic [COORD_BITS-1:0] pt_i,
  output logic                       done_o,
  output logic      [CIW-1:0]        best_label_o,
  output nca_pkg::sum_t              best_dist_o
);

  localparam int SQ_W = 2 * COORD_BITS;

  nca_pkg::step_tag_t tag_mag_q, tag_sq_q, tag_acc_q;
  logic [CIW-1:0]     cl_mag_q, cl_sq_q, cl_acc_q;

  logic [COORD_BITS:0]   diff, diff_neg;
  logic [COORD_BITS-1:0] mag_d, mag_q;
  logic [SQ_W-1:0]       sq_q;
  nca_pkg::sum_t         acc_d, acc_q;
  nca_pkg::sum_t         best_dist_q;
  logic [CIW-1:0]        best_label_q;
  logic                  done_q;
  logic                  take_best;

  // absolute difference, always fits in the coordinate width
  assign diff     = {pt_i[COORD_BITS-1], pt_i} - {cen_i[COORD_BITS-1], cen_i};
  assign diff_neg = ~diff + 1'b1;
  assign mag_d    = diff[COORD_BITS] ? diff_neg[COORD_BITS-1:0] : diff[COORD_BITS-1:0];

  assign acc_d = tag_sq_q.first_dim ? nca_pkg::sum_t'(sq_q)
                                    : nca_pkg::sat_add(acc_q, nca_pkg::sum_t'(sq_q));

  assign take_best = tag_acc_q.valid && tag_acc_q.last_dim &&
                     (tag_acc_q.first_cluster || (acc_q < best_dist_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_mag_q <= '0;
      tag_sq_q  <= '0;
      tag_acc_q <= '0;
      done_q    <= 1'b0;
    end else begin
      tag_mag_q <= tag_i;
      tag_sq_q  <= tag_mag_q;
      tag_acc_q <= tag_sq_q;
      done_q    <= tag_acc_q.valid && tag_acc_q.last_dim && tag_acc_q.last_cluster;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q    <= mag_d;
    cl_mag_q <= cluster_i;
    sq_q     <= mag_q * mag_q;
    cl_sq_q  <= cl_mag_q;
    cl_acc_q <= cl_sq_q;
    if (tag_sq_q.valid) begin
      acc_q <= acc_d;
    end
    if (take_best) begin
      best_dist_q  <= acc_q;
      best_label_q <= cl_acc_q;
    end
  end

  assign done_o       = done_q;
  assign best_label_o = best_label_q;
  assign best_dist_o  = best_dist_q;

endmodule

`default_nettype wire

@@ rtl/nearest_centroid_assign_top.sv @@
// Nearest centroid assignment (k-means assignment step). Op 0 words load one
// centroid coordinate, op 1 words load one point coordinate, op 2 words clear
// the inertia total. An op 1 word whose dim is num_dims-1 starts a distance
// pass: one shared subtract, square and accumulate unit steps through every
// centroid and dimension in use, one product per cycle, reading the centroid
// memory and point buffer each cycle. Such a word holds the input stalled
// until the pass has run and its result is loaded, which waits while the
// previous result is still not taken; the label, squared distance and saturating
// inertia total then sit in an output register until taken. Both memories need
// no clearing after reset.
`default_nettype none
`include "nearest_centroid_assign_top_assert.svh"

module nearest_centroid_assign_top #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 16,
  parameter int COORD_BITS   = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [nca_pkg::OP_W-1:0]            op_i,
  input  wire logic [nca_pkg::FIELD_W-1:0]         cluster_i,
  input  wire logic [nca_pkg::FIELD_W-1:0]         dim_i,
  input  wire logic [COORD_BITS-1:0]               value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [nca_pkg::LABEL_W-1:0]         label_o,
  output logic      [nca_pkg::DIST_W-1:0]          distance_o,
  output logic      [nca_pkg::SUM_W-1:0]           total_inertia_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [nca_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [nca_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  nca_pkg::state_e    state_q, state_d;
  logic [CIW-1:0]     c_q, c_d;
  logic [DIW-1:0]     d_q, d_d;
  nca_pkg::step_tag_t tag_d, tag_q;
  logic [CIW-1:0]     tag_cl_q;

  nca_pkg::cfg_data_t num_clusters_q, num_dims_q;
  nca_pkg::cnt_t      nc, nd;
  nca_pkg::sum_t      inertia_q, inertia_d;

  logic                   in_acc, cfg_acc;
  logic                   cen_we, pt_we;
  logic                   dim_in_range, cl_in_range, dim_last;
  logic                   run_dlast, run_clast;
  logic                   load_out;
  logic                   out_valid_q;
  nca_pkg::label_t        label_q;
  logic [nca_pkg::DIST_W-1:0] distance_q;
  nca_pkg::sum_t          total_q;

  logic [COORD_BITS-1:0]  cen_rdata, pt_rdata;
  logic                   dist_done;
  logic [CIW-1:0]         best_label;
  nca_pkg::sum_t          best_dist;

  assign in_stall_o  = (state_q != nca_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // registers saturate into the supported range when used
  assign nc = (num_clusters_q == '0) ? nca_pkg::cnt_t'(1) :
              (nca_pkg::cnt_t'(num_clusters_q) > nca_pkg::cnt_t'(MAX_CLUSTERS)) ?
              nca_pkg::cnt_t'(MAX_CLUSTERS) : nca_pkg::cnt_t'(num_clusters_q);
  assign nd = (num_dims_q == '0) ? nca_pkg::cnt_t'(1) :
              (nca_pkg::cnt_t'(num_dims_q) > nca_pkg::cnt_t'(MAX_DIMS)) ?
              nca_pkg::cnt_t'(MAX_DIMS) : nca_pkg::cnt_t'(num_dims_q);

  assign dim_in_range = nca_pkg::cnt_t'(dim_i) < nca_pkg::cnt_t'(MAX_DIMS);
  assign cl_in_range  = nca_pkg::cnt_t'(cluster_i) < nca_pkg::cnt_t'(MAX_CLUSTERS);
  assign dim_last     = nca_pkg::cnt_t'(dim_i) == (nd - nca_pkg::cnt_t'(1));
  assign run_dlast    = nca_pkg::cnt_t'(d_q) == (nd - nca_pkg::cnt_t'(1));
  assign run_clast    = nca_pkg::cnt_t'(c_q) == (nc - nca_pkg::cnt_t'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_clusters_q <= nca_pkg::cfg_data_t'(1);
      num_dims_q     <= nca_pkg::cfg_data_t'(1);
    end else if (cfg_acc) begin
      unique case (cfg_index_i)
        nca_pkg::CFG_NUM_CLUSTERS: num_clusters_q <= cfg_data_i;
        nca_pkg::CFG_NUM_DIMS:     num_dims_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    c_d       = c_q;
    d_d       = d_q;
    tag_d     = '0;
    cen_we    = 1'b0;
    pt_we     = 1'b0;
    inertia_d = inertia_q;
    load_out  = 1'b0;
    unique case (state_q)
      nca_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (op_i)
            nca_pkg::OP_LOAD: begin
              cen_we = cl_in_range && dim_in_range;
            end
            nca_pkg::OP_POINT: begin
              pt_we = dim_in_range;
              if (dim_in_range && dim_last) begin
                state_d = nca_pkg::ST_RUN;
                c_d     = '0;
                d_d     = '0;
              end
            end
            nca_pkg::OP_CLEAR: begin
              inertia_d = '0;
            end
            default: ;
          endcase
        end
      end
      nca_pkg::ST_RUN: begin
        tag_d.valid         = 1'b1;
        tag_d.first_dim     = (d_q == '0);
        tag_d.last_dim      = run_dlast;
        tag_d.first_cluster = (c_q == '0);
        tag_d.last_cluster  = run_clast;
        if (run_dlast) begin
          d_d = '0;
          if (run_clast) begin
            state_d = nca_pkg::ST_DRAIN;
          end else begin
            c_d = c_q + 1'b1;
          end
        end else begin
          d_d = d_q + 1'b1;
        end
      end
      nca_pkg::ST_DRAIN: begin
        if (dist_done) begin
          state_d = nca_pkg::ST_EMIT;
        end
      end
      nca_pkg::ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out  = 1'b1;
          inertia_d = nca_pkg::sat_add(inertia_q, best_dist);
          state_d   = nca_pkg::ST_IDLE;
        end
      end
      default: state_d = nca_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nca_pkg::ST_IDLE;
      c_q         <= '0;
      d_q         <= '0;
      tag_q       <= '0;
      inertia_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      c_q       <= c_d;
      d_q       <= d_d;
      tag_q     <= tag_d;
      inertia_q <= inertia_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_cl_q <= c_q;
    if (load_out) begin
      label_q    <= nca_pkg::label_t'(best_label);
      distance_q <= best_dist[nca_pkg::DIST_W-1:0];
      total_q    <= inertia_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign label_o         = label_q;
  assign distance_o      = distance_q;
  assign total_inertia_o = total_q;

  nca_store #(
    .CIW        (CIW),
    .DIW        (DIW),
    .COORD_BITS (COORD_BITS)
  ) u_store (
    .clk_i       (clk_i),
    .cen_we_i    (cen_we),
    .cen_waddr_i ({CIW'(cluster_i), DIW'(dim_i)}),
    .pt_we_i     (pt_we),
    .pt_waddr_i  (DIW'(dim_i)),
    .wdata_i     (value_i),
    .cen_raddr_i ({c_q, d_q}),
    .pt_raddr_i  (d_q),
    .cen_rdata_o (cen_rdata),
    .pt_rdata_o  (pt_rdata)
  );

  nca_dist_unit #(
    .CIW        (CIW),
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tag_i        (tag_q),
    .cluster_i    (tag_cl_q),
    .cen_i        (cen_rdata),
    .pt_i         (pt_rdata),
    .done_o       (dist_done),
    .best_label_o (best_label),
    .best_dist_o  (best_dist)
  );

  `NCA_ASSERT_NOW(a_done_in_drain, dist_done, state_q == nca_pkg::ST_DRAIN)
  `NCA_ASSERT_NOW(a_run_in_range, state_q == nca_pkg::ST_RUN, (nca_pkg::cnt_t'(c_q) < nc) && (nca_pkg::cnt_t'(d_q) < nd))
  `NCA_ASSERT_NEXT(a_inertia_grows, !(in_acc && (op_i == nca_pkg::OP_CLEAR)), inertia_q >= $past(inertia_q))

endmodule

`default_nettype wire

@@ dv/tb_nearest_centroid_assign_top.sv @@
`default_nettype none

module tb_nearest_centroid_assign_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXC          = 16;
  localparam int MAXD          = 16;
  localparam int COORD_W       = 16;
  localparam int RANDOM_WORDS  = 950;
  localparam int SETTLE_CYCLES = MAXC * MAXD + 16;
  localparam int CYCLE_LIMIT   = 2_000_000;

  localparam logic [nca_pkg::OP_W-1:0]      OP_UNUSED   = 2'd3;
  localparam logic [nca_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [nca_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    nca_pkg::label_t            label;
    logic [nca_pkg::DIST_W-1:0] distance;
    nca_pkg::sum_t              total;
  } assignment_t;

  class centroid_board;
    logic signed [COORD_W-1:0] centroid_mem [MAXC][MAXD];
    logic signed [COORD_W-1:0] point_mem [MAXD];
    nca_pkg::cfg_data_t        clusters_raw;
    nca_pkg::cfg_data_t        dims_raw;
    nca_pkg::sum_t             inertia;
    assignment_t               expected_q [$];
    int unsigned               errors;

    function new();
      clusters_raw = 5'd1;
      dims_raw     = 5'd1;
      inertia      = '0;
      errors       = 0;
    endfunction

    static function int unsigned clamp_count(nca_pkg::cfg_data_t raw, int unsigned hi);
      if (raw == 0) return 1;
      if (raw > hi) return hi;
      return raw;
    endfunction

    static function nca_pkg::sum_t clip_add(nca_pkg::sum_t a, nca_pkg::sum_t b);
      logic [nca_pkg::SUM_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[nca_pkg::SUM_W] ? '1 : s[nca_pkg::SUM_W-1:0];
    endfunction

    function void write_reg(logic [nca_pkg::CFG_IDX_W-1:0] idx, nca_pkg::cfg_data_t data);
      if (idx == nca_pkg::CFG_NUM_CLUSTERS) clusters_raw = data;
      else if (idx == nca_pkg::CFG_NUM_DIMS) dims_raw = data;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_word(logic [nca_pkg::OP_W-1:0] w_op, nca_pkg::field_t w_cl,
                            nca_pkg::field_t w_dm, logic signed [COORD_W-1:0] w_val);
      int unsigned     nc;
      int unsigned     nd;
      nca_pkg::sum_t   sq_sum;
      nca_pkg::sum_t   best;
      nca_pkg::label_t best_c;
      longint          diff;
      assignment_t     a;
      nc = clamp_count(clusters_raw, MAXC);
      nd = clamp_count(dims_raw, MAXD);
      if (w_op == nca_pkg::OP_CLEAR) begin
        inertia = '0;
      end else if (w_op == nca_pkg::OP_LOAD) begin
        centroid_mem[w_cl][w_dm] = w_val;
      end else if (w_op == nca_pkg::OP_POINT) begin
        point_mem[w_dm] = w_val;
        if (w_dm == nd - 1) begin
          best   = '0;
          best_c = '0;
          for (int c = 0; c < nc; c++) begin
            sq_sum = '0;
            for (int d = 0; d < nd; d++) begin
              diff   = longint'(point_mem[d]) - longint'(centroid_mem[c][d]);
              sq_sum = clip_add(sq_sum, nca_pkg::sum_t'(diff * diff));
            end
            if (c == 0 || sq_sum < best) begin
              best   = sq_sum;
              best_c = nca_pkg::label_t'(c);
            end
          end
          inertia    = clip_add(inertia, best);
          a.label    = best_c;
          a.distance = best[nca_pkg::DIST_W-1:0];
          a.total    = inertia;
          expected_q = {expected_q, a};
        end
      end
    endfunction

    function void check_result(nca_pkg::label_t l, logic [nca_pkg::DIST_W-1:0] dv,
                               nca_pkg::sum_t t);
      assignment_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: label %0d distance %0d inertia %0d",
                 $time, l, dv, t);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (l !== e.label) begin
        $display("%0t label mismatch: expected %0d actual %0d", $time, e.label, l);
        errors++;
      end
      if (dv !== e.distance) begin
        $display("%0t distance mismatch: expected %0d actual %0d", $time, e.distance, dv);
        errors++;
      end
      if (t !== e.total) begin
        $display("%0t inertia mismatch: expected %0d actual %0d", $time, e.total, t);
        errors++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic [nca_pkg::OP_W-1:0]          op;
  nca_pkg::field_t                   cluster;
  nca_pkg::field_t                   dim;
  logic [COORD_W-1:0]                value;
  logic                              out_valid;
  logic                              out_stall;
  nca_pkg::label_t                   label;
  logic [nca_pkg::DIST_W-1:0]        distance;
  nca_pkg::sum_t                     total;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [nca_pkg::CFG_IDX_W-1:0]     cfg_index;
  nca_pkg::cfg_data_t                cfg_data;

  centroid_board board;
  bit            cent_seen [MAXC][MAXD];
  bit            pt_seen [MAXD];
  int unsigned   cur_nc;
  int unsigned   cur_nd;
  int unsigned   word_count;
  int unsigned   rx_hold;
  int unsigned   cycle_count;
  bit            quiet;

  nearest_centroid_assign_top #(
    .MAX_CLUSTERS(MAXC),
    .MAX_DIMS    (MAXD),
    .COORD_BITS  (COORD_W)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .cluster_i      (cluster),
    .dim_i          (dim),
    .value_i        (value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .label_o        (label),
    .distance_o     (distance),
    .total_inertia_o(total),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random hold-off before each word is taken
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall = 1'b1;
        rx_hold--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(label, distance, total);
      rx_hold = quiet ? 0 : $urandom_range(0, 8);
    end
  end

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3, 4:    return 16'($urandom_range(0, 6) - 3);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_word(logic [nca_pkg::OP_W-1:0] w_op, nca_pkg::field_t w_cl,
                           nca_pkg::field_t w_dm, logic [COORD_W-1:0] w_val);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    op       = w_op;
    cluster  = w_cl;
    dim      = w_dm;
    value    = w_val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(w_op, w_cl, w_dm, w_val);
    if (w_op == nca_pkg::OP_LOAD) cent_seen[w_cl][w_dm] = 1'b1;
    else if (w_op == nca_pkg::OP_POINT) pt_seen[w_dm] = 1'b1;
    if (w_op != OP_UNUSED) word_count++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [nca_pkg::CFG_IDX_W-1:0] idx, nca_pkg::cfg_data_t data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic configure(nca_pkg::cfg_data_t rc, nca_pkg::cfg_data_t rd);
    settle();
    write_reg(nca_pkg::CFG_NUM_CLUSTERS, rc);
    write_reg(nca_pkg::CFG_NUM_DIMS, rd);
    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 5'($urandom()));
    cur_nc = centroid_board::clamp_count(rc, MAXC);
    cur_nd = centroid_board::clamp_count(rd, MAXD);
    // every centroid entry in use gets written before any point completes
    for (int c = 0; c < cur_nc; c++)
      for (int d = 0; d < cur_nd; d++)
        if (!cent_seen[c][d])
          send_word(nca_pkg::OP_LOAD, nca_pkg::field_t'(c), nca_pkg::field_t'(d),
                    rand_coord());
  endtask

  task automatic send_point();
    for (int d = 0; d < cur_nd; d++)
      send_word(nca_pkg::OP_POINT, nca_pkg::field_t'($urandom()), nca_pkg::field_t'(d),
                rand_coord());
  endtask

  // some dimensions left stale, then the closing one
  task automatic send_stale_point();
    bit          ready;
    int unsigned k;
    ready = 1'b1;
    for (int d = 0; d < cur_nd; d++)
      if (!pt_seen[d]) ready = 1'b0;
    if (!ready) begin
      send_point();
    end else begin
      k = (cur_nd > 1) ? $urandom_range(0, cur_nd - 1) : 0;
      repeat (k)
        send_word(nca_pkg::OP_POINT, nca_pkg::field_t'($urandom()),
                  nca_pkg::field_t'($urandom_range(0, cur_nd - 2)), rand_coord());
      send_word(nca_pkg::OP_POINT, nca_pkg::field_t'($urandom()),
                nca_pkg::field_t'(cur_nd - 1), rand_coord());
    end
  endtask

  task automatic random_phase();
    int unsigned quota;
    int unsigned start;
    int unsigned pause_at;
    int unsigned pick;
    bit          paused;
    quota    = $urandom_range(30, 80);
    start    = word_count;
    pause_at = $urandom_range(0, quota);
    paused   = 1'b0;
    while (word_count - start < quota) begin
      if (!paused && word_count - start >= pause_at) begin
        wait_drained();
        paused = 1'b1;
      end
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        send_point();
      end else if (pick < 14) begin
        send_stale_point();
      end else if (pick < 16) begin
        send_word(nca_pkg::OP_LOAD, nca_pkg::field_t'($urandom()),
                  nca_pkg::field_t'($urandom()), rand_coord());
      end else if (pick == 16 && cur_nd < MAXD) begin
        send_word(nca_pkg::OP_POINT, nca_pkg::field_t'($urandom()),
                  nca_pkg::field_t'($urandom_range(cur_nd, MAXD - 1)), rand_coord());
      end else if (pick == 17) begin
        send_word(nca_pkg::OP_CLEAR, nca_pkg::field_t'($urandom()),
                  nca_pkg::field_t'($urandom()), 16'($urandom()));
      end else if (pick == 18) begin
        send_word(OP_UNUSED, nca_pkg::field_t'($urandom()), nca_pkg::field_t'($urandom()),
                  16'($urandom()));
      end else if (cur_nd > 1) begin
        send_word(nca_pkg::OP_POINT, nca_pkg::field_t'($urandom()),
                  nca_pkg::field_t'($urandom_range(0, cur_nd - 2)), rand_coord());
      end else begin
        send_word(nca_pkg::OP_CLEAR, nca_pkg::field_t'($urandom()),
                  nca_pkg::field_t'($urandom()), 16'($urandom()));
      end
    end
  endtask

  initial begin
    int unsigned        base;
    int unsigned        ph;
    nca_pkg::cfg_data_t rc;
    nca_pkg::cfg_data_t rd;
    board       = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    op          = nca_pkg::OP_LOAD;
    cluster     = '0;
    dim         = '0;
    value       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = nca_pkg::CFG_NUM_CLUSTERS;
    cfg_data    = '0;
    cur_nc      = 1;
    cur_nd      = 1;
    word_count  = 0;
    rx_hold     = 0;
    cycle_count = 0;
    quiet       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, tie, clear, unused op, past-end dimension
    configure(5'd2, 5'd1);
    write_reg(CFG_SPARE_A, 5'h1f);
    write_reg(CFG_SPARE_B, 5'h00);
    send_word(nca_pkg::OP_LOAD, 4'd0, 4'd0, 16'h7fff);
    send_word(nca_pkg::OP_LOAD, 4'd1, 4'd0, 16'h8000);
    send_word(nca_pkg::OP_POINT, 4'd15, 4'd0, 16'h8000);
    send_word(nca_pkg::OP_POINT, 4'd0, 4'd0, 16'h7fff);
    send_word(nca_pkg::OP_POINT, 4'd7, 4'd0, 16'h0000);
    send_word(nca_pkg::OP_LOAD, 4'd1, 4'd0, 16'h7fff);
    send_word(nca_pkg::OP_POINT, 4'd3, 4'd0, 16'h0000);
    send_word(nca_pkg::OP_CLEAR, 4'd9, 4'd15, 16'hffff);
    send_word(OP_UNUSED, 4'd15, 4'd15, 16'h5555);
    send_word(nca_pkg::OP_POINT, 4'd0, 4'd0, 16'h8000);
    send_word(nca_pkg::OP_POINT, 4'd0, 4'd15, 16'haaaa);
    send_word(nca_pkg::OP_LOAD, 4'd15, 4'd15, 16'h8000);
    send_word(nca_pkg::OP_POINT, 4'd0, 4'd0, 16'h0001);

    base = word_count;
    ph   = 0;
    while (word_count - base < RANDOM_WORDS) begin
      case (ph)
        0: begin rc = 5'd16; rd = 5'd16; end
        1: begin rc = 5'd1;  rd = 5'd1;  end
        2: begin rc = 5'd16; rd = 5'd1;  end
        3: begin rc = 5'd1;  rd = 5'd16; end
        4: begin rc = 5'd0;  rd = 5'd0;  end
        5: begin rc = 5'd31; rd = 5'd17; end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rc = 5'($urandom());
            rd = 5'($urandom());
          end else begin
            rc = 5'($urandom_range(1, 6));
            rd = 5'($urandom_range(1, 4));
          end
        end
      endcase
      configure(rc, rd);
      quiet = ($urandom_range(0, 3) == 0);
      random_phase();
      ph++;
    end

    quiet = 1'b0;
    settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
